// ===== design/assert_macros.svh =====
// Assertion macros for the sorter RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SDS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorter check failed");

// next-cycle implication, checked outside reset
`define SDS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorter check failed");

`endif

// ===== design/sds_pkg.sv =====
// Types, widths and helpers of the sprite distance sorter.
// No dependencies; used by every module of the block.
`default_nettype none

package sds_pkg;

	localparam int DIST_W  = 33;
	localparam int IDX_W   = 5;
	localparam int PLAY_W  = 16;
	localparam int CFG_I_W = 2;

	localparam logic [CFG_I_W-1:0] REG_PLAYER_X = 2'd0;
	localparam logic [CFG_I_W-1:0] REG_PLAYER_Y = 2'd1;

	// sort key: squared distance, arrival number
	typedef struct packed {
		logic [DIST_W-1:0] sq_dist;
		logic [IDX_W-1:0]  idx;
	} sds_key_t;

	typedef struct packed {
		logic     valid;
		sds_key_t key;
	} sds_entry_t;

	// side info riding along the distance pipeline
	typedef struct packed {
		logic             last;
		logic             stored;
		logic [IDX_W-1:0] idx;
	} sds_tag_t;

	// true if a goes out before b: farther first, higher index on ties
	function automatic logic key_gt(input sds_key_t a, input sds_key_t b);
		logic res;
		if (a.sq_dist != b.sq_dist) begin
			res = a.sq_dist > b.sq_dist;
		end else begin
			res = a.idx > b.idx;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== design/sprite_distance_sorter_core.sv =====
// Sprite distance sorter: takes one sprite position per item, keeps up to
// MAX_SPRITES of them sorted by squared distance to the player as they
// arrive, and on the item marked last sends the whole set out farthest first
// (equal distances: higher arrival number first). Loading runs at one item
// per cycle. Each item passes a three-register distance pipeline (abs diff,
// squares, sum) and is placed into the cell chain in the cycle after. Once
// the last item has left the pipeline, the drain flag is set and results
// move from the chain head to the output register, one result per cycle
// while out_ready holds, the chain shifting one cell per result. From the
// last item until the final result has left the chain, in_ready is low.
// Sprites beyond capacity are dropped, take no arrival number, and mark
// every result of the set with dropped. Player position is written through
// the cfg channel, which is always ready; write it only while the block is
// idle.
`default_nettype none
`include "assert_macros.svh"

module sprite_distance_sorter_core import sds_pkg::*; #(
	parameter int MAX_SPRITES = 32,
	parameter int COORD_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_I_W-1:0]    cfg_index,
	input  wire logic [PLAY_W-1:0]     cfg_data,
	// sprite items in
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_BITS-1:0] sprite_x,
	input  wire logic [COORD_BITS-1:0] sprite_y,
	input  wire logic                  is_last,
	// sorted items out
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [IDX_W-1:0]           sprite_index,
	output logic [DIST_W-1:0]          distance_sq,
	output logic                       last_out,
	output logic                       dropped
);

	localparam int CNT_W = $clog2(MAX_SPRITES + 1);

	// config registers
	logic [PLAY_W-1:0] player_x_q, player_y_q;

	// set bookkeeping
	logic             busy_q;      // last item taken, set not fully drained
	logic             drain_q;     // chain is being emptied
	logic [CNT_W-1:0] count_q;     // sprites stored in the open set
	logic             overflow_q;  // open set lost a sprite
	logic [CNT_W-1:0] remain_q;    // results still to pop in this run
	logic             run_drop_q;

	// output register
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_last_q;
	logic              out_drop_q;

	logic     accept, stored, pop, ins;
	sds_tag_t in_tag;
	logic     p_v;
	sds_key_t p_key;
	sds_tag_t p_tag;

	sds_entry_t cell_e [MAX_SPRITES];
	logic       beat   [MAX_SPRITES];

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q;
	assign accept    = in_valid && in_ready;
	assign stored    = count_q < CNT_W'(MAX_SPRITES);

	assign in_tag.last   = is_last;
	assign in_tag.stored = stored;
	assign in_tag.idx    = IDX_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= '0;
			player_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PLAYER_X: player_x_q <= cfg_data;
				REG_PLAYER_Y: player_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sds_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (accept),
		.sx     (sprite_x),
		.sy     (sprite_y),
		.px     (COORD_BITS'(player_x_q)),
		.py     (COORD_BITS'(player_y_q)),
		.in_tag (in_tag),
		.out_v  (p_v),
		.out_key(p_key),
		.out_tag(p_tag)
	);

	// chain: cell 0 holds the farthest entry
	assign ins = p_v && p_tag.stored;
	assign pop = drain_q && (!out_valid_q || out_ready);

	for (genvar i = 0; i < MAX_SPRITES; i++) begin : g_cell
		sds_entry_t prev_e, next_e;
		logic       prev_beat;
		if (i == 0) begin : g_head
			assign prev_e    = '0;
			assign prev_beat = 1'b0;
		end else begin : g_body
			assign prev_e    = cell_e[i-1];
			assign prev_beat = beat[i-1];
		end
		if (i == MAX_SPRITES - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_mid
			assign next_e = cell_e[i+1];
		end
		sds_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.new_k    (p_key),
			.prev_e   (prev_e),
			.prev_beat(prev_beat),
			.next_e   (next_e),
			.ins      (ins),
			.shift    (pop),
			.own_e    (cell_e[i]),
			.beat     (beat[i])
		);
	end

	// set control: count on accept, arm the drain when the last item lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			drain_q    <= 1'b0;
			count_q    <= '0;
			overflow_q <= 1'b0;
			remain_q   <= '0;
			run_drop_q <= 1'b0;
		end else begin
			if (accept) begin
				if (is_last) begin
					busy_q     <= 1'b1;
					count_q    <= '0;
					overflow_q <= 1'b0;
					remain_q   <= count_q + CNT_W'(stored);
					run_drop_q <= overflow_q || !stored;
				end else if (stored) begin
					count_q <= count_q + 1'b1;
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (p_v && p_tag.last) begin
				drain_q <= 1'b1;
			end
			if (pop) begin
				remain_q <= remain_q - 1'b1;
				if (remain_q == CNT_W'(1)) begin
					drain_q <= 1'b0;
					busy_q  <= 1'b0;
				end
			end
		end
	end

	// output register, fed from the chain head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_idx_q  <= cell_e[0].key.idx;
			out_dist_q <= cell_e[0].key.sq_dist;
			out_last_q <= remain_q == CNT_W'(1);
			out_drop_q <= run_drop_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sprite_index = out_idx_q;
	assign distance_sq  = out_dist_q;
	assign last_out     = out_last_q;
	assign dropped      = out_drop_q;

	// no input taken while the chain drains
	`SDS_ASSERT_IMP(a_no_in_during_drain, drain_q, !in_ready)
	// the head cell holds a real entry whenever one is popped
	`SDS_ASSERT_IMP(a_pop_head_valid, pop, cell_e[0].valid)
	// inserts and drains never overlap
	`SDS_ASSERT_IMP(a_no_ins_in_drain, ins, !drain_q)
	// popping the final entry ends the run and reopens the input
	`SDS_ASSERT_NXT(a_run_end, pop && remain_q == CNT_W'(1), !drain_q && in_ready)

endmodule

`default_nettype wire

// ===== design/sds_dist.sv =====
// Three-stage squared-distance pipeline: |diff|, squares, sum.
// Depends on sds_pkg.
`default_nettype none

module sds_dist import sds_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_v,
	input  wire logic [COORD_BITS-1:0] sx,
	input  wire logic [COORD_BITS-1:0] sy,
	input  wire logic [COORD_BITS-1:0] px,
	input  wire logic [COORD_BITS-1:0] py,
	input  wire sds_tag_t              in_tag,
	output logic                       out_v,
	output sds_key_t                   out_key,
	output sds_tag_t                   out_tag
);

	localparam int SQ_W = 2 * COORD_BITS;

	logic                  v_s1, v_s2, v_s3;
	logic [COORD_BITS-1:0] dx_s1, dy_s1;
	logic [SQ_W-1:0]       sqx_s2, sqy_s2;
	logic [DIST_W-1:0]     dist_s3;
	sds_tag_t              tag_s1, tag_s2, tag_s3;
	logic [SQ_W:0]         sum;

	assign sum = (SQ_W+1)'(sqx_s2) + (SQ_W+1)'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= (px >= sx) ? (px - sx) : (sx - px);
		dy_s1   <= (py >= sy) ? (py - sy) : (sy - py);
		tag_s1  <= in_tag;
		sqx_s2  <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		sqy_s2  <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		tag_s2  <= tag_s1;
		dist_s3 <= DIST_W'(sum);
		tag_s3  <= tag_s2;
	end

	assign out_v           = v_s3;
	assign out_key.sq_dist = dist_s3;
	assign out_key.idx     = tag_s3.idx;
	assign out_tag         = tag_s3;

endmodule

`default_nettype wire

// ===== design/sds_cell.sv =====
// One slot of the sorted insertion chain; holds one entry.
// Depends on sds_pkg.
`default_nettype none

module sds_cell import sds_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire sds_key_t   new_k,
	input  wire sds_entry_t prev_e,
	input  wire logic       prev_beat,
	input  wire sds_entry_t next_e,
	input  wire logic       ins,
	input  wire logic       shift,
	output sds_entry_t      own_e,
	output logic            beat
);

	logic     valid_q;
	sds_key_t key_q;

	// new key displaces this slot's content (empty slots always lose)
	assign beat = ins && (!valid_q || key_gt(new_k, key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next_e.valid;
		end else if (beat) begin
			// an empty neighbor moving down keeps this slot empty
			valid_q <= prev_beat ? prev_e.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= next_e.key;
		end else if (beat) begin
			key_q <= prev_beat ? prev_e.key : new_k;
		end
	end

	assign own_e.valid = valid_q;
	assign own_e.key   = key_q;

endmodule

`default_nettype wire
